### rtl/lin_master_frame_engine_assert.svh
// ----------------------------------------------------------------------------
// LIN master frame engine assertion macros
// Short forms for the concurrent checks used in the engine's RTL.
// ----------------------------------------------------------------------------
`ifndef LIN_MASTER_FRAME_ENGINE_ASSERT_SVH
`define LIN_MASTER_FRAME_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LMFE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("LIN frame engine check failed");

// Next-cycle implication, disabled while reset is high.
`define LMFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("LIN frame engine check failed");

`endif

### rtl/lmfe_pkg.sv
// ----------------------------------------------------------------------------
// LIN master frame engine package
// Shared word types, codes, sizes and the identifier parity and checksum helpers.
// ----------------------------------------------------------------------------
package lmfe_pkg;

   localparam int BufferBytes  = 16;
   localparam int MaxDataBytes = 8;
   localparam int PosWidth     = $clog2(BufferBytes + 1);

   localparam logic [7:0] SYNC_BYTE = 8'h55;

   typedef enum logic {
      ACT_REQUEST = 1'b0,
      ACT_RX_BYTE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      KIND_BREAK  = 2'd0,
      KIND_TX     = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_PENDING = 3'd0,
      ST_VALID   = 3'd1,
      ST_PIDERR  = 3'd2,
      ST_SUMERR  = 3'd3,
      ST_LENERR  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_PID  = 3'd1,
      PH_DATA = 3'd2,
      PH_CSUM = 3'd3,
      PH_DONE = 3'd4
   } phase_type;

   typedef struct packed {
      action_type  action;
      logic [5:0]  frame_id;
      logic [3:0]  data_len;
      logic [63:0] write_data;
      logic [3:0]  expected_len;
      logic [7:0]  rx_byte;
   } req_word_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_byte;
      logic        last;
      status_type  rx_status;
      logic [63:0] payload;
      logic [3:0]  payload_len;
   } rsp_word_type;

   // Control from the top level to the receive capture.
   typedef struct packed {
      logic arm;
      logic take;
   } cap_ctl_type;

   // Position of the transmit sequencer within the current request.
   typedef struct packed {
      logic first;
      logic last;
   } seq_stat_type;

   // Protected identifier: standard P0/P1 parity over the six identifier bits.
   function automatic logic [7:0] lin_pid(input logic [5:0] id);
      logic p0;
      logic p1;
      p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0, id};
   endfunction

   // Eight-bit sum with the carry wrapped back into bit 0.
   function automatic logic [7:0] sum_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[7:0] + {7'd0, s[8]};
   endfunction

   function automatic logic len_rejected(input logic [3:0] dlen, input logic [3:0] elen);
      return (dlen > 4'(MaxDataBytes)) || (elen > 4'(MaxDataBytes));
   endfunction

endpackage

### rtl/lmfe_tx_seq.sv
// ----------------------------------------------------------------------------
// LIN master frame engine transmit sequencer
// Walks through the words of one held request, one word per step.
// ----------------------------------------------------------------------------
module lmfe_tx_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  lmfe_pkg::req_word_type item,
   input  logic                  step,
   output lmfe_pkg::rsp_word_type word,
   output lmfe_pkg::seq_stat_type stat
);

   localparam logic [3:0] IdxBreak = 4'd0;
   localparam logic [3:0] IdxSync  = 4'd1;
   localparam logic [3:0] IdxPid   = 4'd2;
   localparam logic [3:0] IdxData  = 4'd3;

   logic [3:0] idx_ff;
   logic [3:0] idx_in;
   logic [7:0] sum_ff;
   logic [7:0] sum_in;

   logic [7:0] pid;
   logic [2:0] data_sel;
   logic [7:0] data_byte;
   logic [3:0] csum_idx;
   logic       reject;

   always_comb begin
      pid       = lmfe_pkg::lin_pid(item.frame_id);
      data_sel  = 3'(idx_ff - IdxData);
      data_byte = item.write_data[{data_sel, 3'b000} +: 8];
      csum_idx  = IdxData + item.data_len;
      reject    = lmfe_pkg::len_rejected(item.data_len, item.expected_len);

      word             = '0;
      word.kind        = lmfe_pkg::KIND_TX;
      word.rx_status   = lmfe_pkg::ST_PENDING;
      sum_in           = sum_ff;

      if (reject) begin
         word.kind      = lmfe_pkg::KIND_STATUS;
         word.rx_status = lmfe_pkg::ST_LENERR;
         word.last      = 1'b1;
      end else if (idx_ff == IdxBreak) begin
         word.kind = lmfe_pkg::KIND_BREAK;
      end else if (idx_ff == IdxSync) begin
         word.tx_byte = lmfe_pkg::SYNC_BYTE;
      end else if (idx_ff == IdxPid) begin
         word.tx_byte = pid;
         word.last    = (item.data_len == 4'd0);
         sum_in       = pid;
      end else if (idx_ff == csum_idx) begin
         word.tx_byte = ~sum_ff;
         word.last    = 1'b1;
      end else begin
         word.tx_byte = data_byte;
         sum_in       = lmfe_pkg::sum_add(sum_ff, data_byte);
      end

      stat.first = (idx_ff == IdxBreak);
      stat.last  = word.last;

      if (!step) begin
         idx_in = idx_ff;
         sum_in = sum_ff;
      end else if (word.last) begin
         idx_in = IdxBreak;
      end else begin
         idx_in = idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= IdxBreak;
      end else begin
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

endmodule

### rtl/lmfe_rx_capture.sv
// ----------------------------------------------------------------------------
// LIN master frame engine receive capture
// Hunts for sync, checks the identifier echo, gathers data and checks the sum.
// ----------------------------------------------------------------------------
module lmfe_rx_capture (
   input  logic                   clock,
   input  logic                   reset,
   input  lmfe_pkg::req_word_type item,
   input  lmfe_pkg::cap_ctl_type  ctl,
   output lmfe_pkg::rsp_word_type word
);

   lmfe_pkg::phase_type            phase_ff;
   lmfe_pkg::phase_type            phase_in;
   lmfe_pkg::status_type           verdict_ff;
   lmfe_pkg::status_type           verdict_in;
   logic [lmfe_pkg::PosWidth-1:0]  pos_ff;
   logic [lmfe_pkg::PosWidth-1:0]  pos_in;
   logic [7:0]                     pid_ff;
   logic [7:0]                     pid_in;
   logic [3:0]                     len_ff;
   logic [3:0]                     len_in;
   logic [3:0]                     idx_ff;
   logic [3:0]                     idx_in;
   logic [7:0]                     sum_ff;
   logic [7:0]                     sum_in;
   logic [63:0]                    cap_ff;
   logic [63:0]                    cap_in;

   logic [7:0] b;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= lmfe_pkg::PH_HUNT;
         verdict_ff <= lmfe_pkg::ST_PENDING;
         pos_ff     <= '0;
         pid_ff     <= '0;
         len_ff     <= '0;
         idx_ff     <= '0;
         sum_ff     <= '0;
         cap_ff     <= '0;
      end else begin
         phase_ff   <= phase_in;
         verdict_ff <= verdict_in;
         pos_ff     <= pos_in;
         pid_ff     <= pid_in;
         len_ff     <= len_in;
         idx_ff     <= idx_in;
         sum_ff     <= sum_in;
         cap_ff     <= cap_in;
      end
   end

   always_comb begin
      b          = item.rx_byte;
      phase_in   = phase_ff;
      verdict_in = verdict_ff;
      pos_in     = pos_ff;
      pid_in     = pid_ff;
      len_in     = len_ff;
      idx_in     = idx_ff;
      sum_in     = sum_ff;
      cap_in     = cap_ff;

      if (ctl.arm) begin
         // A new request clears the capture and rearms it.
         phase_in   = lmfe_pkg::PH_HUNT;
         verdict_in = lmfe_pkg::ST_PENDING;
         pos_in     = '0;
         idx_in     = '0;
         sum_in     = '0;
         cap_in     = '0;
         if (lmfe_pkg::len_rejected(item.data_len, item.expected_len)) begin
            phase_in   = lmfe_pkg::PH_DONE;
            verdict_in = lmfe_pkg::ST_LENERR;
         end else begin
            pid_in = lmfe_pkg::lin_pid(item.frame_id);
            len_in = item.expected_len;
         end
      end else if (ctl.take && phase_ff != lmfe_pkg::PH_DONE &&
                   pos_ff < lmfe_pkg::PosWidth'(lmfe_pkg::BufferBytes)) begin
         pos_in = pos_ff + lmfe_pkg::PosWidth'(1);
         unique case (phase_ff)
            lmfe_pkg::PH_HUNT: begin
               if (b == lmfe_pkg::SYNC_BYTE) begin
                  phase_in = lmfe_pkg::PH_PID;
               end
            end
            lmfe_pkg::PH_PID: begin
               if (b != pid_ff) begin
                  verdict_in = lmfe_pkg::ST_PIDERR;
                  phase_in   = lmfe_pkg::PH_DONE;
               end else begin
                  sum_in   = pid_ff;
                  idx_in   = '0;
                  phase_in = (len_ff == 4'd0) ? lmfe_pkg::PH_CSUM : lmfe_pkg::PH_DATA;
               end
            end
            lmfe_pkg::PH_DATA: begin
               for (int k = 0; k < 8; k++) begin
                  if (idx_ff[2:0] == 3'(k)) begin
                     cap_in[8*k +: 8] = cap_ff[8*k +: 8] | b;
                  end
               end
               sum_in = lmfe_pkg::sum_add(sum_ff, b);
               idx_in = idx_ff + 4'd1;
               if (idx_in >= len_ff) begin
                  phase_in = lmfe_pkg::PH_CSUM;
               end
            end
            lmfe_pkg::PH_CSUM: begin
               verdict_in = (~sum_ff == b) ? lmfe_pkg::ST_VALID : lmfe_pkg::ST_SUMERR;
               phase_in   = lmfe_pkg::PH_DONE;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      // Status word reflects the capture after this byte.
      word           = '0;
      word.kind      = lmfe_pkg::KIND_STATUS;
      word.last      = 1'b1;
      word.rx_status = verdict_in;
      if (verdict_in == lmfe_pkg::ST_VALID) begin
         word.payload     = cap_in;
         word.payload_len = len_in;
      end
   end

endmodule

### rtl/lin_master_frame_engine.sv
// ----------------------------------------------------------------------------
// LIN master frame engine
// Builds LIN master headers and write frames, and checks received responses.
// ----------------------------------------------------------------------------
// Usage. Words arrive on the req_ channel (valid/stall). A request word
// (action 0) produces a break marker, the sync byte, the protected identifier
// and, if data_len is not zero, the write bytes and their enhanced checksum,
// one rsp_ word per cycle while the output is not stalled, the final one
// flagged by last. It also rearms the receive capture. A request with a
// length above eight gives a single length-rejected status word instead. A
// received-byte word (action 1) gives exactly one status word.
// Each input word waits in the holding register, and its result words pass
// through the output register. Throughput: one result word per cycle while
// rsp_stall allows. A received-byte word gives one result word; a request
// gives one (rejected) up to twelve, as a single holding register feeds the
// output register. The next input word is taken in the same cycle as the
// last word of the previous one moves to the output register.
// Reset clears the capture: armed identifier and length are zero and the
// verdict is pending. While rsp_stall is high the output word holds, and
// the held input word waits behind it. req_stall is high whenever a word is
// held and does not hand its last result word over in this cycle, so it
// stays high through all but the final word of a request and for as long as
// a full output register is stalled.
// ----------------------------------------------------------------------------
`include "lin_master_frame_engine_assert.svh"

module lin_master_frame_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lmfe_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lmfe_pkg::rsp_word_type rsp_word
);

   // Holding register for the input word currently being worked on.
   logic                   slot_valid_ff;
   logic                   slot_valid_in;
   lmfe_pkg::req_word_type slot_ff;

   // Output register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   lmfe_pkg::rsp_word_type rsp_word_ff;
   lmfe_pkg::rsp_word_type rsp_word_in;

   lmfe_pkg::rsp_word_type seq_word;
   lmfe_pkg::seq_stat_type seq_stat;
   lmfe_pkg::rsp_word_type cap_word;
   lmfe_pkg::cap_ctl_type  cap_ctl;

   logic is_rx;
   logic out_load;
   logic step;
   logic word_last;
   logic req_accept;

   lmfe_tx_seq u_tx_seq (
      .clock (clock),
      .reset (reset),
      .item  (slot_ff),
      .step  (step && !is_rx),
      .word  (seq_word),
      .stat  (seq_stat)
   );

   lmfe_rx_capture u_rx_capture (
      .clock (clock),
      .reset (reset),
      .item  (slot_ff),
      .ctl   (cap_ctl),
      .word  (cap_word)
   );

   always_comb begin
      is_rx     = (slot_ff.action == lmfe_pkg::ACT_RX_BYTE);
      // The output register may load whenever it is empty or being drained.
      out_load  = !rsp_valid_ff || !rsp_stall;
      step      = slot_valid_ff && out_load;
      word_last = is_rx || seq_stat.last;

      // The capture is rearmed as a request's first word leaves, and takes a
      // received byte as its status word leaves, so it follows word order.
      cap_ctl.arm  = step && !is_rx && seq_stat.first;
      cap_ctl.take = step && is_rx;

      req_stall  = slot_valid_ff && !(step && word_last);
      req_accept = req_valid && !req_stall;

      if (req_accept) begin
         slot_valid_in = 1'b1;
      end else if (step && word_last) begin
         slot_valid_in = 1'b0;
      end else begin
         slot_valid_in = slot_valid_ff;
      end

      rsp_valid_in = out_load ? step : rsp_valid_ff;
      rsp_word_in  = is_rx ? cap_word : seq_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         slot_ff <= req_word;
      end
      if (out_load && step) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `LMFE_ASSERT_NEXT(a_slot_frees, clock, reset, step && word_last && !req_accept, !slot_valid_ff)
   `LMFE_ASSERT_NEXT(a_step_fills_out, clock, reset, step, rsp_valid_ff)
   `LMFE_ASSERT_SAME(a_status_is_last, clock, reset, rsp_valid_ff && rsp_word_ff.kind == lmfe_pkg::KIND_STATUS, rsp_word_ff.last)
   `LMFE_ASSERT_SAME(a_payload_only_valid, clock, reset, rsp_valid_ff && rsp_word_ff.rx_status != lmfe_pkg::ST_VALID, rsp_word_ff.payload == 64'd0 && rsp_word_ff.payload_len == 4'd0)

endmodule

### tb/tb_lin_master_frame_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LIN master frame engine testbench
// Drives request and received-byte words through the engine with random gaps
// and output stalls, and checks every result word against a local predictor.
// ----------------------------------------------------------------------------
module tb_lin_master_frame_engine;

   import lmfe_pkg::*;

   // The slowest legal run is some 130 words, each giving up to twelve result
   // words that may each wait out the longest random stall, plus the input
   // gaps and one long hold-off. That stays well below this bound, which
   // leaves ample headroom.
   localparam int CycleLimit   = 400000;
   localparam int RandomWords  = 80;
   localparam int HoldOffStart = 45;
   localparam int HoldOffLen   = 150;
   localparam int DrainCycles  = 20;

   logic         clock;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_stall;
   req_word_type req_word    = '0;
   logic         rsp_valid;
   logic         rsp_stall   = 1'b0;
   rsp_word_type rsp_word;

   lin_master_frame_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // -------------------------------------------------------------------------
   // Words still to be offered, expected result words, and run bookkeeping.
   // -------------------------------------------------------------------------
   req_word_type pending_words[$];
   rsp_word_type expected_words[$];
   int           mismatch_count = 0;
   int           taken_count    = 0;
   int           cycle_count    = 0;
   logic         req_taken      = 1'b0;
   int           req_gap        = 0;
   int           stall_left     = 0;
   int           hold_left      = 0;
   logic         hold_done      = 1'b0;
   logic         calm;

   // For a stretch of every sixty words neither side idles, so that the engine
   // is also seen running back to back.
   assign calm = (taken_count % 60) >= 42;

   // -------------------------------------------------------------------------
   // Predictor state: the receive capture and the armed response.
   // The reset values here match what the engine holds after its reset.
   // -------------------------------------------------------------------------
   logic [4:0]  cap_pos      = '0;
   phase_type   cap_phase    = PH_HUNT;
   logic [7:0]  armed_pid    = '0;
   logic [3:0]  armed_len    = '0;
   logic [3:0]  data_count   = '0;
   logic [7:0]  running_sum  = '0;
   logic [63:0] captured     = '0;
   status_type  cap_verdict  = ST_PENDING;

   // Protected identifier: the six identifier bits with the P0 and P1 parity
   // bits on top; P1 is odd parity, hence the inversion.
   function automatic logic [7:0] protected_id(input logic [5:0] id);
      return {~^(id & 6'h3A), ^(id & 6'h17), id};
   endfunction

   // One step of the enhanced checksum: an eight-bit add whose carry wraps
   // round into the sum.
   function automatic logic [7:0] wrap_add(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s > 9'd255)
         s = s - 9'd255;
      return s[7:0];
   endfunction

   // Works out the result words of one accepted word and updates the capture.
   task automatic predict_words(input req_word_type w);
      rsp_word_type r;
      logic [7:0]   sum;
      logic [7:0]   b;
      r = '0;
      if (w.action == ACT_REQUEST) begin
         cap_pos     = '0;
         cap_phase   = PH_HUNT;
         data_count  = '0;
         running_sum = '0;
         captured    = '0;
         cap_verdict = ST_PENDING;
         if (w.data_len > 4'(MaxDataBytes) || w.expected_len > 4'(MaxDataBytes)) begin
            // Over-long request: nothing goes on the bus, and the capture is
            // parked on a length verdict until the next good request.
            cap_verdict = ST_LENERR;
            cap_phase   = PH_DONE;
            r.kind      = KIND_STATUS;
            r.last      = 1'b1;
            r.rx_status = ST_LENERR;
            expected_words.push_back(r);
            return;
         end
         armed_pid = protected_id(w.frame_id);
         armed_len = w.expected_len;
         r.kind = KIND_BREAK;
         expected_words.push_back(r);
         r.kind    = KIND_TX;
         r.tx_byte = SYNC_BYTE;
         expected_words.push_back(r);
         r.tx_byte = armed_pid;
         r.last    = (w.data_len == 4'd0);
         expected_words.push_back(r);
         if (w.data_len != 4'd0) begin
            sum = armed_pid;
            for (int i = 0; i < int'(w.data_len); i++) begin
               b         = w.write_data[i*8 +: 8];
               sum       = wrap_add(sum, b);
               r.tx_byte = b;
               expected_words.push_back(r);
            end
            r.tx_byte = ~sum;
            r.last    = 1'b1;
            expected_words.push_back(r);
         end
      end else begin
         b = w.rx_byte;
         // Once a verdict is reached, or the buffer has taken its fill since
         // the last request, further bytes change nothing.
         if (cap_phase != PH_DONE && cap_pos < 5'(BufferBytes)) begin
            cap_pos = cap_pos + 5'd1;
            case (cap_phase)
               PH_HUNT: begin
                  if (b == SYNC_BYTE)
                     cap_phase = PH_PID;
               end
               PH_PID: begin
                  if (b != armed_pid) begin
                     cap_verdict = ST_PIDERR;
                     cap_phase   = PH_DONE;
                  end else begin
                     running_sum = armed_pid;
                     data_count  = '0;
                     cap_phase   = (armed_len == 4'd0) ? PH_CSUM : PH_DATA;
                  end
               end
               PH_DATA: begin
                  captured[{data_count[2:0], 3'b000} +: 8] =
                     captured[{data_count[2:0], 3'b000} +: 8] | b;
                  running_sum = wrap_add(running_sum, b);
                  data_count  = data_count + 4'd1;
                  if (data_count >= armed_len)
                     cap_phase = PH_CSUM;
               end
               default: begin
                  cap_verdict = (~running_sum == b) ? ST_VALID : ST_SUMERR;
                  cap_phase   = PH_DONE;
               end
            endcase
         end
         r.kind      = KIND_STATUS;
         r.last      = 1'b1;
         r.rx_status = cap_verdict;
         if (cap_verdict == ST_VALID) begin
            r.payload     = captured;
            r.payload_len = armed_len;
         end
         expected_words.push_back(r);
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus helpers. Fields that a word does not use are filled at random so
   // that every bit of every field sees both values.
   // -------------------------------------------------------------------------
   function automatic req_word_type request_word(input logic [5:0] id, input logic [3:0] dlen,
                                                 input logic [63:0] data,
                                                 input logic [3:0] elen);
      req_word_type w;
      w.action       = ACT_REQUEST;
      w.frame_id     = id;
      w.data_len     = dlen;
      w.write_data   = data;
      w.expected_len = elen;
      w.rx_byte      = 8'($urandom_range(0, 255));
      return w;
   endfunction

   function automatic req_word_type bus_byte_word(input logic [7:0] b);
      req_word_type w;
      w.action       = ACT_RX_BYTE;
      w.frame_id     = 6'($urandom_range(0, 63));
      w.data_len     = 4'($urandom_range(0, 15));
      w.write_data   = {$urandom, $urandom};
      w.expected_len = 4'($urandom_range(0, 15));
      w.rx_byte      = b;
      return w;
   endfunction

   // A random bus byte that can never be taken for the sync byte.
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      return (b == SYNC_BYTE) ? 8'h54 : b;
   endfunction

   // Half the waits are nil; most of the rest are short, and a few are long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10)
         return 0;
      else if (r < 18)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Queues the bytes a slave would put on the bus in answer to a header:
   // optional line noise, the sync byte, the identifier echo, the data and the
   // checksum, with the echo or the checksum spoilt on request.
   task automatic queue_response(input logic [7:0] pid, input logic [3:0] elen, input int lead,
                                 input bit bad_pid, input bit bad_sum);
      logic [7:0] sum;
      logic [7:0] b;
      for (int i = 0; i < lead; i++)
         pending_words.push_back(bus_byte_word(noise_byte()));
      pending_words.push_back(bus_byte_word(SYNC_BYTE));
      if (bad_pid) begin
         pending_words.push_back(bus_byte_word(pid ^ (8'h01 << $urandom_range(0, 7))));
         return;
      end
      pending_words.push_back(bus_byte_word(pid));
      sum = pid;
      for (int i = 0; i < int'(elen); i++) begin
         b   = 8'($urandom_range(0, 255));
         sum = wrap_add(sum, b);
         pending_words.push_back(bus_byte_word(b));
      end
      sum = ~sum;
      if (bad_sum)
         sum = sum ^ 8'($urandom_range(1, 255));
      pending_words.push_back(bus_byte_word(sum));
   endtask

   // -------------------------------------------------------------------------
   // Input side. The accept flag is taken at the rising edge; the driver works
   // at the falling edge and only moves on once the current word has gone.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            predict_words(req_word);
            taken_count++;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (pending_words.size() > 0) begin
            req_valid <= 1'b1;
            req_word  <= pending_words.pop_front();
            req_gap   <= calm ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Output side. Besides the random stalls, there is one long hold-off early
   // in the random part, during which the sender keeps offering words so that
   // the engine fills up and stalls its input.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && taken_count >= HoldOffStart) begin
         rsp_stall <= 1'b1;
         hold_left <= HoldOffLen;
         hold_done <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm && $urandom_range(0, 3) == 0)
            stall_left <= pick_gap();
      end
   end

   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
   endtask

   // Each word taken from the engine is held against the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t: result word with nothing expected, expected none, got %h",
                     $time, rsp_word);
            mismatch_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_word.kind !== want.kind)
               report_field("kind", 64'(want.kind), 64'(rsp_word.kind));
            if (rsp_word.tx_byte !== want.tx_byte)
               report_field("tx_byte", 64'(want.tx_byte), 64'(rsp_word.tx_byte));
            if (rsp_word.last !== want.last)
               report_field("last", 64'(want.last), 64'(rsp_word.last));
            if (rsp_word.rx_status !== want.rx_status)
               report_field("rx_status", 64'(want.rx_status), 64'(rsp_word.rx_status));
            if (rsp_word.payload !== want.payload)
               report_field("payload", want.payload, rsp_word.payload);
            if (rsp_word.payload_len !== want.payload_len)
               report_field("payload_len", 64'(want.payload_len), 64'(rsp_word.payload_len));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int         directed_count;
      int         pick;
      logic [5:0] id;
      logic [3:0] elen;

      // Before any request the capture is armed for identifier zero with no
      // data, so sync, a zero echo and a checksum of all ones is a good frame.
      // The fourth byte arrives after the verdict and must only repeat it.
      pending_words.push_back(bus_byte_word(SYNC_BYTE));
      pending_words.push_back(bus_byte_word(8'h00));
      pending_words.push_back(bus_byte_word(8'hFF));
      pending_words.push_back(bus_byte_word(8'h00));

      // Largest frame both ways: identifier 63, eight bytes of all ones.
      pending_words.push_back(request_word(6'h3F, 4'd8, '1, 4'd8));
      queue_response(protected_id(6'h3F), 4'd8, 0, 1'b0, 1'b0);

      // Header only, all fields at zero.
      pending_words.push_back(request_word(6'h00, 4'd0, '0, 4'd0));

      // Over-long write, then a byte that must still report the rejection.
      pending_words.push_back(request_word(6'h2A, 4'd15, {$urandom, $urandom}, 4'd0));
      pending_words.push_back(bus_byte_word(SYNC_BYTE));

      // Over-long response length.
      pending_words.push_back(request_word(6'h15, 4'd1, '0, 4'd15));

      // Identifier echo spoilt, after a byte of line noise.
      pending_words.push_back(request_word(6'h15, 4'd3, {$urandom, $urandom}, 4'd2));
      queue_response(protected_id(6'h15), 4'd2, 1, 1'b1, 1'b0);

      // Checksum spoilt.
      pending_words.push_back(request_word(6'h0C, 4'd0, '0, 4'd1));
      queue_response(protected_id(6'h0C), 4'd1, 0, 1'b0, 1'b1);

      directed_count = pending_words.size();

      // Random part: mostly complete frames with random content, the rest
      // rejected requests, buffer overruns, stray bytes and lone requests.
      while (pending_words.size() < directed_count + RandomWords) begin
         pick = $urandom_range(0, 9);
         id   = 6'($urandom_range(0, 63));
         elen = 4'($urandom_range(0, 8));
         if (pick <= 5) begin
            pending_words.push_back(request_word(id, 4'($urandom_range(0, 8)),
                                                 {$urandom, $urandom}, elen));
            queue_response(protected_id(id), elen, $urandom_range(0, 2),
                           $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
            repeat ($urandom_range(0, 2))
               pending_words.push_back(bus_byte_word(8'($urandom_range(0, 255))));
         end else if (pick == 6) begin
            if ($urandom_range(0, 1) == 1)
               pending_words.push_back(request_word(id, 4'($urandom_range(9, 15)),
                                                    {$urandom, $urandom}, elen));
            else
               pending_words.push_back(request_word(id, elen, {$urandom, $urandom},
                                                    4'($urandom_range(9, 15))));
            repeat ($urandom_range(0, 2))
               pending_words.push_back(bus_byte_word(8'($urandom_range(0, 255))));
         end else if (pick == 7) begin
            // No sync ever turns up, so the buffer fills and the rest are
            // dropped; a late sync byte must not restart the hunt.
            pending_words.push_back(request_word(id, 4'd0, '0, elen));
            repeat ($urandom_range(16, 18))
               pending_words.push_back(bus_byte_word(noise_byte()));
            pending_words.push_back(bus_byte_word(SYNC_BYTE));
         end else if (pick == 8) begin
            repeat ($urandom_range(1, 4))
               pending_words.push_back(bus_byte_word(8'($urandom_range(0, 255))));
         end else begin
            pending_words.push_back(request_word(id, 4'($urandom_range(0, 15)),
                                                 {$urandom, $urandom},
                                                 4'($urandom_range(0, 15))));
         end
      end

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
      // Wait out DrainCycles so that any stray word behind the last one shows up.
      repeat (DrainCycles) @(posedge clock);

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
